// ----- rtl/rfgd_pkg.sv -----
// Shared types, constants and scaling functions for the gap-delimited
// remote control frame decoder. No dependencies.
`default_nettype none

package rfgd_pkg;

   localparam int REQ_W      = 40;  // rx_byte, arrival_us
   localparam int RSP_W      = 72;  // six result fields, padded to whole bytes
   localparam int HEAD_DEPTH = 6;   // bytes of a frame that carry the payload

   localparam logic [15:0] GAP_RESET  = 16'd2000;
   localparam logic [11:0] STICK_BASE = 12'd723;
   localparam logic [11:0] MIRROR_REF = 12'd3000;
   // floor(x*25/33) = (x * 1588775) >> 21 for every 11-bit x.
   localparam logic [31:0] STICK_RECIP = 32'd1588775;
   localparam int          STICK_SHIFT = 21;

   typedef struct packed {
      logic [1:0]  pad;
      logic [10:0] switch_two;
      logic [10:0] switch_one;
      logic [11:0] stick_c;
      logic [11:0] stick_d;
      logic [11:0] stick_b_mirrored;
      logic [11:0] stick_a;
   } rsp_word_type;

   function automatic logic [11:0] scale_stick(input logic [10:0] raw);
      logic [31:0] prod;
      prod = {21'd0, raw} * STICK_RECIP;
      return {1'b0, prod[31:STICK_SHIFT]} + STICK_BASE;
   endfunction

   function automatic logic [10:0] scale_switch(input logic [1:0] s);
      logic [10:0] v;
      case (s)
         2'd0:    v = 11'd500;
         2'd1:    v = 11'd1000;
         2'd2:    v = 11'd1500;
         default: v = 11'd2000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rc_frame_gap_decoder_core.sv -----
// Top level of the gap-delimited remote control frame decoder.
// Depends on rfgd_pkg for field layout, constants and scaling functions.
//
//   Channel  Direction  Word contents (lowest bit first)
//   req_     in         rx_byte[7:0], arrival_us[39:8]
//   rsp_     out        stick_a, stick_b_mirrored, stick_d, stick_c,
//                       switch_one, switch_two, two zero bits
//   csr_     in         gap_time_us (write only, no handshake)
//
// One word is accepted every cycle while req_tready is high. A word is captured
// in the input register and processed once the result register can take a value;
// there the gap check, frame offset update and stick scaling (one constant
// multiply per stick) all complete, and a completed frame is loaded into the
// result register. Reset is synchronous and active high and
// returns the gap time to 2000 us, the offset and the previous arrival time to
// zero. While a result waits on rsp_tready the input register holds its word
// and req_tready falls only if that register is full.
`default_nettype none

module rc_frame_gap_decoder_core #(
   parameter int FRAME_BYTES = 18
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // rx_byte [7:0], arrival_us [39:8]
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   input  wire logic [rfgd_pkg::REQ_W-1:0] req_tdata,
   // stick_a [11:0], stick_b_mirrored [23:12], stick_d [35:24],
   // stick_c [47:36], switch_one [58:48], switch_two [69:59], zero [71:70]
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   output      logic [rfgd_pkg::RSP_W-1:0] rsp_tdata,
   input  wire logic                       csr_wr_en,
   input  wire logic [15:0]                csr_wr_data
);
   import rfgd_pkg::*;

   localparam int OFS_W = $clog2(FRAME_BYTES);
   localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(FRAME_BYTES - 1);

   // Configuration register.
   logic [15:0] gap_ff;

   // Input register.
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic [31:0] s1_time_ff;

   // Frame tracking state.
   logic [31:0]      last_ff, last_in;
   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic [7:0]       head_ff [HEAD_DEPTH];
   logic [7:0]       head_in [HEAD_DEPTH];

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic             advance, process, gap, keep, done, load;
   logic [31:0]      elapsed;
   logic [OFS_W-1:0] ofs_eff;

   // The result register can take a new value when it is empty or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_comb begin
      // Wrap-around difference, so a timer roll-over still measures the idle time.
      elapsed = s1_time_ff - last_ff;
      gap     = elapsed >= {16'd0, gap_ff};
      ofs_eff = gap ? '0 : ofs_ff;
      // A byte that would open a frame without a preceding gap is dropped.
      keep    = gap || (ofs_ff != '0);
      done    = keep && (ofs_eff == LAST_OFS);
      load    = process && done;

      last_in = process ? s1_time_ff : last_ff;
      ofs_in  = ofs_ff;
      if (process) begin
         if (!keep || done) begin
            ofs_in = '0;
         end else begin
            ofs_in = ofs_eff + 1'b1;
         end
      end

      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (process && keep && (ofs_eff == OFS_W'(i))) begin
            head_in[i] = s1_byte_ff;
         end else begin
            head_in[i] = head_ff[i];
         end
      end

      // Decode from the next-value head bytes, since with a six-byte frame the
      // final byte is also the last payload byte.
      rsp_word_in.pad              = 2'b00;
      rsp_word_in.stick_a          = scale_stick({head_in[1][2:0], head_in[0]});
      rsp_word_in.stick_b_mirrored = MIRROR_REF
                                     - scale_stick({head_in[2][5:0], head_in[1][7:3]});
      rsp_word_in.stick_d          = scale_stick({head_in[5][3:0], head_in[4][7:1]});
      rsp_word_in.stick_c          = scale_stick({head_in[4][0], head_in[3],
                                                  head_in[2][7:6]});
      rsp_word_in.switch_one       = scale_switch(head_in[5][7:6]);
      rsp_word_in.switch_two       = scale_switch(head_in[5][5:4]);

      rsp_valid_in = advance ? load : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= GAP_RESET;
         s1_valid_ff  <= 1'b0;
         last_ff      <= '0;
         ofs_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         last_ff      <= last_in;
         ofs_ff       <= ofs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_time_ff <= req_tdata[39:8];
      end
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_ff[i] <= head_in[i];
      end
      if (load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/rfgd_checker.sv -----
// Port-level checks for rc_frame_gap_decoder_core and the bind that attaches
// them. Depends on rfgd_pkg for the result word layout.
`default_nettype none

module rfgd_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [rfgd_pkg::RSP_W-1:0] rsp_tdata
);
   import rfgd_pkg::*;

   rsp_word_type w;
   assign w = rsp_tdata;

   // A stalled result word stays presented and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_stick_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> w.stick_a >= 12'd723 && w.stick_a <= 12'd2273
                  && w.stick_c >= 12'd723 && w.stick_c <= 12'd2273
                  && w.stick_d >= 12'd723 && w.stick_d <= 12'd2273
                  && w.stick_b_mirrored >= 12'd727 && w.stick_b_mirrored <= 12'd2277
                  && w.pad == 2'b00)
      else $error("stick value out of range or padding set");

   a_switch_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (w.switch_one == 11'd500 || w.switch_one == 11'd1000
                   || w.switch_one == 11'd1500 || w.switch_one == 11'd2000)
                  && (w.switch_two == 11'd500 || w.switch_two == 11'd1000
                   || w.switch_two == 11'd1500 || w.switch_two == 11'd2000))
      else $error("switch value not a valid position");

   // The input side only stalls behind a result word that is held off.
   a_ready_when_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while the result side was free");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rc_frame_gap_decoder_core rfgd_checker u_rfgd_checker (.*);

`default_nettype wire

// ----- tb/tb_rc_frame_gap_decoder_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rc_frame_gap_decoder_core: sends timed byte words, decodes
// frames alongside the block and compares every result word field by field.
// Depends on rfgd_pkg and the core RTL only.

module tb_rc_frame_gap_decoder_core;
   import rfgd_pkg::*;

   localparam int FRAME_LEN     = 18;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_RUNS} ready_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;     // rx_byte [7:0], arrival_us [39:8]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;          // stick_a, stick_b_mirrored, stick_d, stick_c,
                                           // switch_one, switch_two, zero
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;

   // Decoder state as the testbench sees it.
   logic [15:0]        gap_us;
   logic [31:0]        prev_arrival;
   int unsigned        frame_pos;
   logic [7:0]         frame_head [HEAD_DEPTH];
   rsp_word_type       frames_due [$];

   logic [31:0]        now_us;
   int                 burst_left;
   int                 hold_request;
   int                 error_count;
   int                 frames_checked;
   int                 words_kept;
   int                 words_dropped;
   int                 input_stall_cycles;

   always #5 clock = ~clock;

   rc_frame_gap_decoder_core #(
      .FRAME_BYTES (FRAME_LEN)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic logic [11:0] stick_us(input logic [10:0] raw);
      int unsigned v;
      v = (int'(raw) * 25) / 33 + 723;
      return v[11:0];
   endfunction

   function automatic logic [10:0] switch_us(input logic [1:0] s);
      int unsigned v;
      v = 500 + 500 * int'(s);
      return v[10:0];
   endfunction

   // Follows one accepted word through the gap check and frame assembly, and
   // queues the decoded frame when the word completes one.
   task automatic decode_word(input logic [7:0] b, input logic [31:0] t);
      logic [31:0]  idle;
      logic [47:0]  bits;
      logic         drop;
      rsp_word_type w;
      idle = t - prev_arrival;
      prev_arrival = t;
      drop = 1'b0;
      if (idle >= {16'd0, gap_us}) begin
         frame_pos = 0;
      end else if (frame_pos == 0) begin
         drop = 1'b1;
      end
      if (drop) begin
         words_dropped++;
      end else begin
         words_kept++;
         if (frame_pos < HEAD_DEPTH) begin
            frame_head[frame_pos] = b;
         end
         frame_pos++;
         if (frame_pos == FRAME_LEN) begin
            frame_pos = 0;
            bits = {frame_head[5], frame_head[4], frame_head[3],
                    frame_head[2], frame_head[1], frame_head[0]};
            w.pad              = '0;
            w.stick_a          = stick_us(bits[10:0]);
            w.stick_b_mirrored = 12'd3000 - stick_us(bits[21:11]);
            w.stick_c          = stick_us(bits[32:22]);
            w.stick_d          = stick_us(bits[43:33]);
            w.switch_two       = switch_us(bits[45:44]);
            w.switch_one       = switch_us(bits[47:46]);
            frames_due.push_back(w);
         end
      end
   endtask

   // Offers one word, idling between bursts, and waits until it is taken.
   task automatic send_word(input logic [7:0] b, input logic [31:0] t);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
      req_tdata  <= {t, b};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      decode_word(b, t);
   endtask

   task automatic send_after(input logic [7:0] b, input logic [31:0] delta);
      now_us = now_us + delta;
      send_word(b, now_us);
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] inner_delta();
      if ($urandom_range(0, 7) == 0) begin
         return 32'(gap_us) - 1;
      end
      return $urandom_range(0, 32'(gap_us) - 1);
   endfunction

   // A frame start after a proper gap, then body_len words close behind it.
   // Needs a gap time of at least one.
   task automatic send_frame(input int body_len);
      logic [31:0] delta;
      delta = ($urandom_range(0, 15) == 0) ? ($urandom | 32'h0001_0000)
                                           : (32'(gap_us) + $urandom_range(0, 3000));
      send_after(rand_byte(), delta);
      repeat (body_len) send_after(rand_byte(), inner_delta());
   endtask

   // Mostly whole frames, some cut short, some loose words.
   task automatic random_traffic(input int target);
      int goal;
      goal = words_kept + target;
      while (words_kept < goal) begin
         case ($urandom_range(0, 9))
            8:       send_frame($urandom_range(0, FRAME_LEN - 2));
            9:       send_after(rand_byte(), $urandom_range(0, 32'(gap_us)));
            default: send_frame(FRAME_LEN - 1);
         endcase
      end
   endtask

   // The register is only written once the block has gone quiet.
   task automatic set_gap(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gap_us = value;
   endtask

   task automatic test_first_word_and_wrap;
      // Straight after reset the previous arrival counts as zero, so 1999 us is no gap.
      send_after(8'hA5, 32'd1999);
      // All-ones head across the timestamp wrap, then the longest idle inside a frame.
      now_us = 32'hFFFF_FFFC;
      send_word(8'hFF, now_us);
      repeat (5) send_after(8'hFF, 32'd1);
      repeat (12) send_after(rand_byte(), 32'd1999);
      // Frame just closed and no gap: this word is thrown away.
      send_after(8'h00, 32'd5);
      random_traffic(80);
   endtask

   task automatic test_zero_gap;
      // Every word restarts the frame, so nothing is ever decoded.
      set_gap(16'd0);
      repeat (8) send_after(rand_byte(), $urandom_range(0, 3));
   endtask

   task automatic test_wide_gap;
      set_gap(16'hFFFF);
      send_after(8'h00, 32'd65535);
      repeat (FRAME_LEN - 1) send_after(8'h00, 32'd65534);
      random_traffic(60);
   endtask

   task automatic test_narrow_gap;
      // Only words sharing a timestamp stay in one frame.
      set_gap(16'd1);
      random_traffic(50);
   endtask

   task automatic test_random_gap;
      set_gap(16'($urandom_range(2, 65534)));
      random_traffic(80);
   endtask

   task automatic test_backpressure;
      // The receiver holds off while the sender keeps pushing whole frames,
      // so the result register fills and the input side has to stall.
      hold_request = HOLD_CYCLES;
      burst_left   = 200;
      repeat (4) send_frame(FRAME_LEN - 1);
   endtask

   task automatic test_reset_gap_value;
      set_gap(16'd2000);
      random_traffic(40);
   endtask

   // Receiver: changes its stall pattern now and then, and honours a hold-off.
   initial begin
      ready_mode_type mode;
      int             mode_left;
      int             hold_left;
      mode      = RDY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode      = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RDY_ALWAYS: rsp_tready <= 1'b1;
               RDY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               RDY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:    rsp_tready <= ((mode_left / 8) % 2 == 0);
            endcase
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Checker: every result word taken is matched against the oldest decoded frame.
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_word_type'(rsp_tdata);
         if (frames_due.size() == 0) begin
            error_count++;
            $display("%0t: result word with none expected, expected nothing, got %h",
                     $time, rsp_tdata);
         end else begin
            want = frames_due.pop_front();
            frames_checked++;
            check_field("stick_a", want.stick_a, got.stick_a);
            check_field("stick_b_mirrored", want.stick_b_mirrored, got.stick_b_mirrored);
            check_field("stick_d", want.stick_d, got.stick_d);
            check_field("stick_c", want.stick_c, got.stick_c);
            check_field("switch_one", want.switch_one, got.switch_one);
            check_field("switch_two", want.switch_two, got.switch_two);
         end
      end
   end

   initial begin
      gap_us             = 16'd2000;
      prev_arrival       = '0;
      frame_pos          = 0;
      foreach (frame_head[i]) frame_head[i] = '0;
      now_us             = '0;
      burst_left         = 0;
      hold_request       = 0;
      error_count        = 0;
      frames_checked     = 0;
      words_kept         = 0;
      words_dropped      = 0;
      input_stall_cycles = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_first_word_and_wrap();
      test_zero_gap();
      test_wide_gap();
      test_narrow_gap();
      test_random_gap();
      test_backpressure();
      test_reset_gap_value();

      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("Sent %0d framed words and %0d stray words; %0d frames decoded and compared.",
               words_kept, words_dropped, frames_checked);
      $display("Gap times 0, 1, 2000, 65535 and one random value; input stalled %0d cycles.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run timed out.");
      $display("CHECK FAILED");
      $finish;
   end

endmodule
